// ===== src/lpfp_pkg.sv =====
// Shared types and constants for the length-prefixed frame parser.
`default_nettype none

package lpfp_pkg;

  localparam int unsigned MAX_FIELDS_DEFAULT = 256;
  localparam int unsigned MAX_FIELDS_W       = 17;

  localparam logic [8:0] COUNT_SAT = 9'd256;
  localparam logic [1:0] HDR_LAST  = 2'd3;

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_FLEN  = 2'd1,
    PH_FHDR  = 2'd2,
    PH_FDATA = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TYPE  = 2'd0,
    KIND_FLEN  = 2'd1,
    KIND_FHDR  = 2'd2,
    KIND_FDATA = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TRUNC    = 2'd1,
    ERR_OVERRUN  = 2'd2,
    ERR_TOO_MANY = 2'd3
  } err_t;

endpackage

`default_nettype wire

// ===== src/length_prefixed_frame_parser.sv =====
// Top level of the length-prefixed frame parser: byte classifier and frame tracker.
`default_nettype none

// The parser takes one byte per cycle and returns one result item per byte in the cycle
// after it is accepted, through an output register; with the output side ready it sustains
// one item every cycle, set by the single register stage between input handshake and the
// result. A frame is a type byte, a four-byte big-endian payload length and fields, each a
// four-byte big-endian length and its data. A frame always ends after exactly its payload
// length; a field header or field that does not fit is cut there and flagged in the error
// code, and fields at index MAX_FIELDS or above are flagged as too many.
module length_prefixed_frame_parser
  import lpfp_pkg::*;
#(
  parameter int unsigned MAX_FIELDS = MAX_FIELDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // byte_value, message_type, field_index, offset_in_field, field_end,
  // fields_in_frame, error_code, zero fill
  output logic [71:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser,   // byte_kind
  output logic             m_axis_tlast    // frame_end
);

  localparam logic [MAX_FIELDS_W-1:0] MaxFields = MAX_FIELDS_W'(MAX_FIELDS);

  phase_t      phase, phase_next;
  logic [1:0]  hdr_cnt, hdr_cnt_next;
  logic [31:0] frame_rem, frame_rem_next;
  logic [31:0] field_rem, field_rem_next;
  logic [31:0] len_shift, len_shift_next;
  logic [7:0]  cur_type, cur_type_next;
  logic [8:0]  field_cnt, field_cnt_next;
  logic [31:0] data_off, data_off_next;

  logic        accept;
  logic [7:0]  b;
  logic [31:0] frame_len_shifted;
  logic [31:0] frame_dec;
  logic [31:0] field_dec;
  logic [31:0] len_shifted;
  logic [8:0]  field_cnt_inc;
  logic        hdr_last;
  logic        too_many;

  kind_t       r_kind;
  logic [7:0]  r_index;
  logic [31:0] r_off;
  logic        r_fe;
  logic        r_fre;
  logic [8:0]  r_done;
  err_t        r_err;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign b             = s_axis_tdata;

  always_comb begin
    frame_len_shifted = {frame_rem[23:0], b};
    len_shifted       = {len_shift[23:0], b};
    frame_dec         = (frame_rem != 32'd0) ? frame_rem - 32'd1 : 32'd0;
    field_dec         = (field_rem != 32'd0) ? field_rem - 32'd1 : 32'd0;
    field_cnt_inc     = (field_cnt == COUNT_SAT) ? field_cnt : field_cnt + 9'd1;
    hdr_last          = (hdr_cnt == HDR_LAST);
    too_many          = {8'd0, field_cnt} >= MaxFields;
  end

  always_comb begin
    phase_next     = phase;
    hdr_cnt_next   = hdr_cnt;
    frame_rem_next = frame_rem;
    field_rem_next = field_rem;
    len_shift_next = len_shift;
    cur_type_next  = cur_type;
    field_cnt_next = field_cnt;
    data_off_next  = data_off;
    unique case (phase)
      PH_FLEN: begin
        frame_rem_next = frame_len_shifted;
        hdr_cnt_next   = hdr_cnt + 2'd1;
        if (hdr_last) begin
          if (frame_len_shifted == 32'd0) begin
            phase_next = PH_TYPE;
          end else begin
            phase_next     = PH_FHDR;
            len_shift_next = 32'd0;
          end
        end
      end
      PH_FHDR: begin
        frame_rem_next = frame_dec;
        len_shift_next = len_shifted;
        hdr_cnt_next   = hdr_cnt + 2'd1;
        if (!hdr_last) begin
          if (frame_dec == 32'd0) begin
            phase_next = PH_TYPE;
          end
        end else if (len_shifted == 32'd0) begin
          field_cnt_next = field_cnt_inc;
          if (frame_dec == 32'd0) begin
            phase_next = PH_TYPE;
          end else begin
            phase_next     = PH_FHDR;
            len_shift_next = 32'd0;
          end
        end else if (frame_dec == 32'd0) begin
          field_cnt_next = field_cnt_inc;
          phase_next     = PH_TYPE;
        end else begin
          field_rem_next = len_shifted;
          data_off_next  = 32'd0;
          phase_next     = PH_FDATA;
        end
      end
      PH_FDATA: begin
        frame_rem_next = frame_dec;
        field_rem_next = field_dec;
        data_off_next  = data_off + 32'd1;
        if (field_dec == 32'd0) begin
          field_cnt_next = field_cnt_inc;
          if (frame_dec == 32'd0) begin
            phase_next = PH_TYPE;
          end else begin
            phase_next     = PH_FHDR;
            hdr_cnt_next   = 2'd0;
            len_shift_next = 32'd0;
          end
        end else if (frame_dec == 32'd0) begin
          field_cnt_next = field_cnt_inc;
          phase_next     = PH_TYPE;
        end
      end
      default: begin
        cur_type_next  = b;
        field_cnt_next = 9'd0;
        frame_rem_next = 32'd0;
        field_rem_next = 32'd0;
        data_off_next  = 32'd0;
        hdr_cnt_next   = 2'd0;
        len_shift_next = 32'd0;
        phase_next     = PH_FLEN;
      end
    endcase
  end

  always_comb begin
    r_kind  = KIND_TYPE;
    r_index = 8'd0;
    r_off   = 32'd0;
    r_fe    = 1'b0;
    r_fre   = 1'b0;
    r_err   = ERR_NONE;
    unique case (phase)
      PH_FLEN: begin
        r_kind = KIND_FLEN;
        r_fre  = hdr_last && (frame_len_shifted == 32'd0);
      end
      PH_FHDR: begin
        r_kind  = KIND_FHDR;
        r_index = field_cnt[8] ? 8'hFF : field_cnt[7:0];
        if (!hdr_last) begin
          if (frame_dec == 32'd0) begin
            r_err = ERR_TRUNC;
            r_fre = 1'b1;
          end
        end else if (len_shifted == 32'd0) begin
          r_fe  = 1'b1;
          r_fre = (frame_dec == 32'd0);
        end else if (frame_dec == 32'd0) begin
          r_err = ERR_OVERRUN;
          r_fe  = 1'b1;
          r_fre = 1'b1;
        end
        if (r_err == ERR_NONE && too_many) begin
          r_err = ERR_TOO_MANY;
        end
      end
      PH_FDATA: begin
        r_kind  = KIND_FDATA;
        r_index = field_cnt[8] ? 8'hFF : field_cnt[7:0];
        r_off   = data_off;
        if (field_dec == 32'd0) begin
          r_fe  = 1'b1;
          r_fre = (frame_dec == 32'd0);
        end else if (frame_dec == 32'd0) begin
          r_err = ERR_OVERRUN;
          r_fe  = 1'b1;
          r_fre = 1'b1;
        end
        if (r_err == ERR_NONE && too_many) begin
          r_err = ERR_TOO_MANY;
        end
      end
      default: begin
        r_kind = KIND_TYPE;
      end
    endcase
    r_done = (r_kind == KIND_FHDR || r_kind == KIND_FDATA) ? field_cnt_next : 9'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_TYPE;
      hdr_cnt   <= 2'd0;
      frame_rem <= 32'd0;
      field_rem <= 32'd0;
      len_shift <= 32'd0;
      cur_type  <= 8'd0;
      field_cnt <= 9'd0;
      data_off  <= 32'd0;
    end else if (accept) begin
      phase     <= phase_next;
      hdr_cnt   <= hdr_cnt_next;
      frame_rem <= frame_rem_next;
      field_rem <= field_rem_next;
      len_shift <= len_shift_next;
      cur_type  <= cur_type_next;
      field_cnt <= field_cnt_next;
      data_off  <= data_off_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {4'd0, r_err, r_done, r_fe, r_off, r_index, cur_type_next, b};
      m_axis_tuser <= r_kind;
      m_axis_tlast <= r_fre;
    end
  end

  a_field_cnt_sat: assert property (@(posedge clk) disable iff (rst)
    field_cnt <= COUNT_SAT)
    else $error("field counter above saturation");

  a_frame_end_to_type: assert property (@(posedge clk) disable iff (rst)
    accept && r_fre |=> phase == PH_TYPE)
    else $error("frame end did not return to type byte");

  a_trunc_marks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[67:66] == ERR_TRUNC |-> m_axis_tlast && !m_axis_tdata[56])
    else $error("truncated header item has wrong end marks");

  a_overrun_marks: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[67:66] == ERR_OVERRUN |-> m_axis_tlast && m_axis_tdata[56])
    else $error("overrun item has wrong end marks");

  a_type_clears: assert property (@(posedge clk) disable iff (rst)
    accept && phase != PH_FLEN && phase != PH_FHDR && phase != PH_FDATA
      |=> field_cnt == 9'd0 && phase == PH_FLEN)
    else $error("type byte did not start a new frame");

endmodule

`default_nettype wire
